>>> rtl/lvc_pkg.sv
// Shared types and constants for the low voltage cutoff controller.
package lvc_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_ON    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER = 2'd2;

  localparam logic [SAMPLE_W-1:0] CUTOFF_RST  = 10'd736;
  localparam logic [SAMPLE_W-1:0] LOW_RST     = 10'd791;
  localparam logic [SAMPLE_W-1:0] RECOVER_RST = 10'd886;

  typedef logic [SAMPLE_W-1:0] level_t;

  typedef struct packed {
    level_t cutoff;
    level_t low;
    level_t recover;
  } levels_t;

  typedef struct packed {
    logic              load_enable;
    logic              green_led;
    logic              red_led;
    logic [MODE_W-1:0] mode;
    logic              window_done;
  } result_t;

endpackage

>>> rtl/low_voltage_cutoff_controller.sv
// Top level: input register, controller core, result register and level registers.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, in_operation, in_sample
//  out     | output    | out_valid, out_ready, out_load_enable, out_green_led,
//          |           | out_red_led, out_mode, out_window_done
//  cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready is high; each result is presented after its
// input transaction passes through the input register and then the result register.
// The state update sits between the input and result registers, so each item sees
// the state left by the one before it.
// Synchronous active-low reset restores the levels and on mode; no clearing pass.
// A stalled result holds the input register; in_ready drops only when both are full.
module low_voltage_cutoff_controller #(
  parameter int unsigned OVERSAMPLE_LOG2 = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [lvc_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_load_enable,
  output logic                             out_green_led,
  output logic                             out_red_led,
  output logic [lvc_pkg::MODE_W-1:0]       out_mode,
  output logic                             out_window_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lvc_pkg::SAMPLE_W-1:0]     cfg_data
);

  logic                         in_valid_r;
  logic                         in_op_r;
  logic [lvc_pkg::SAMPLE_W-1:0] in_sample_r;
  logic                         out_valid_r;
  lvc_pkg::result_t             res_r;
  lvc_pkg::result_t             res;
  lvc_pkg::levels_t             levels;
  logic                         advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r     <= in_operation;
      in_sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  lvc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .levels    (levels)
  );

  lvc_core #(
    .OVERSAMPLE_LOG2 (OVERSAMPLE_LOG2)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .op     (in_op_r),
    .sample (in_sample_r),
    .levels (levels),
    .result (res)
  );

  assign out_valid       = out_valid_r;
  assign out_load_enable = res_r.load_enable;
  assign out_green_led   = res_r.green_led;
  assign out_red_led     = res_r.red_led;
  assign out_mode        = res_r.mode;
  assign out_window_done = res_r.window_done;

endmodule

>>> rtl/lvc_cfg_regs.sv
// Threshold level registers written through the configuration channel.
module lvc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lvc_pkg::SAMPLE_W-1:0]     cfg_data,
  output lvc_pkg::levels_t                 levels
);

  lvc_pkg::levels_t levels_r;

  assign cfg_ready = 1'b1;
  assign levels    = levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r.cutoff  <= lvc_pkg::CUTOFF_RST;
      levels_r.low     <= lvc_pkg::LOW_RST;
      levels_r.recover <= lvc_pkg::RECOVER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lvc_pkg::REG_CUTOFF:  levels_r.cutoff  <= cfg_data;
        lvc_pkg::REG_LOW:     levels_r.low     <= cfg_data;
        lvc_pkg::REG_RECOVER: levels_r.recover <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/lvc_core.sv
// Window averaging and on/off/sleep state machine with its state registers.
module lvc_core #(
  parameter int unsigned OVERSAMPLE_LOG2 = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          op,
  input  logic [lvc_pkg::SAMPLE_W-1:0]  sample,
  input  lvc_pkg::levels_t              levels,
  output lvc_pkg::result_t              result
);

  localparam int unsigned ACC_W = lvc_pkg::SAMPLE_W + OVERSAMPLE_LOG2;
  localparam int unsigned CNT_W = OVERSAMPLE_LOG2 + 1;
  localparam logic [CNT_W-1:0] WIN = CNT_W'(1) << OVERSAMPLE_LOG2;

  logic [lvc_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                       flag_r, flag_nxt;
  logic                       green_r, green_nxt;
  logic                       red_r, red_nxt;
  logic                       load_r, load_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       done;
  logic                       awake;
  logic [ACC_W-1:0]           sum;
  logic [CNT_W-1:0]           cnt_inc;
  logic [lvc_pkg::SAMPLE_W-1:0] avg;

  assign awake   = (mode_r == lvc_pkg::MODE_ON) || (mode_r == lvc_pkg::MODE_OFF);
  assign sum     = acc_r + ACC_W'(sample);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign avg     = sum[ACC_W-1:OVERSAMPLE_LOG2];

  always_comb begin
    mode_nxt  = mode_r;
    flag_nxt  = flag_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    load_nxt  = load_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    if (op) begin
      acc_nxt = '0;
      cnt_nxt = '0;
      if (awake) begin
        mode_nxt  = lvc_pkg::MODE_SLEEP;
        green_nxt = 1'b0;
        red_nxt   = 1'b0;
        load_nxt  = 1'b0;
      end else if (flag_r) begin
        mode_nxt  = lvc_pkg::MODE_OFF;
        green_nxt = 1'b0;
        red_nxt   = 1'b1;
        load_nxt  = 1'b0;
      end else begin
        mode_nxt  = lvc_pkg::MODE_ON;
        green_nxt = 1'b1;
        red_nxt   = 1'b0;
        load_nxt  = 1'b1;
      end
    end else if (awake) begin
      if (cnt_inc == WIN) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        done    = 1'b1;
        if (mode_r == lvc_pkg::MODE_ON) begin
          if (avg < levels.cutoff) begin
            flag_nxt  = 1'b1;
            mode_nxt  = lvc_pkg::MODE_OFF;
            green_nxt = 1'b0;
            red_nxt   = 1'b1;
            load_nxt  = 1'b0;
          end else if (avg < levels.low) begin
            red_nxt = 1'b1;
          end
        end else if (avg > levels.recover) begin
          flag_nxt  = 1'b0;
          mode_nxt  = lvc_pkg::MODE_ON;
          green_nxt = 1'b1;
          red_nxt   = 1'b0;
          load_nxt  = 1'b1;
        end
      end else begin
        acc_nxt = sum;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lvc_pkg::MODE_ON;
      flag_r  <= 1'b0;
      green_r <= 1'b1;
      red_r   <= 1'b0;
      load_r  <= 1'b1;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      flag_r  <= flag_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
      load_r  <= load_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign result.load_enable = load_nxt;
  assign result.green_led   = green_nxt;
  assign result.red_led     = red_nxt;
  assign result.mode        = mode_nxt;
  assign result.window_done = done;

  // load and green track each other and only while on
  a_load_on: assert property (@(posedge clk) disable iff (!rst_n)
    load_r |-> (mode_r == lvc_pkg::MODE_ON && green_r))
    else $error("load enabled outside on mode");

  a_off_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == lvc_pkg::MODE_OFF) |-> (flag_r && red_r && !load_r))
    else $error("off mode without cutoff flag");

  a_win_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < WIN) && (mode_r != lvc_pkg::MODE_SLEEP || cnt_r == '0))
    else $error("window count out of range");

  a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op && awake) |=> (mode_r == lvc_pkg::MODE_SLEEP && !red_r && !green_r))
    else $error("sleep entry left outputs lit");

endmodule

>>> dv/tb_low_voltage_cutoff_controller.sv
// Self-checking testbench for the low voltage cutoff controller: directed table, random windows.
module tb_low_voltage_cutoff_controller;

  localparam int WIN_LOG2 = 3;
  localparam int WINDOW = 1 << WIN_LOG2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_SET = 100;
  localparam int NUM_SETS = 6;

  localparam lvc_pkg::result_t ST_ON      = '{1'b1, 1'b1, 1'b0, lvc_pkg::MODE_ON, 1'b0};
  localparam lvc_pkg::result_t ST_OFF     = '{1'b0, 1'b0, 1'b1, lvc_pkg::MODE_OFF, 1'b0};
  localparam lvc_pkg::result_t ST_SLEEP   = '{1'b0, 1'b0, 1'b0, lvc_pkg::MODE_SLEEP, 1'b0};
  localparam lvc_pkg::result_t ST_CUTOFF  = '{1'b0, 1'b0, 1'b1, lvc_pkg::MODE_OFF, 1'b1};
  localparam lvc_pkg::result_t ST_RECOVER = '{1'b1, 1'b1, 1'b0, lvc_pkg::MODE_ON, 1'b1};

  typedef struct {
    logic             op;
    lvc_pkg::level_t  smp;
    logic             typed;
    lvc_pkg::result_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  lvc_pkg::level_t in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_load_enable;
  logic out_green_led;
  logic out_red_led;
  logic [lvc_pkg::MODE_W-1:0] out_mode;
  logic out_window_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lvc_pkg::CFG_IDX_W-1:0] cfg_index = lvc_pkg::REG_CUTOFF;
  lvc_pkg::level_t cfg_data = '0;

  // typed expectation riding along with the current input transaction
  logic row_typed = 1'b0;
  lvc_pkg::result_t row_exp = '0;

  int unsigned send_idle = 35;
  int unsigned recv_idle = 66;
  int cycle = 0;
  int mismatches = 0;
  int accepted = 0;
  int results = 0;
  int windows = 0;
  int cutoffs = 0;

  // predictor state
  lvc_pkg::levels_t lvl = '{lvc_pkg::CUTOFF_RST, lvc_pkg::LOW_RST, lvc_pkg::RECOVER_RST};
  logic [lvc_pkg::MODE_W-1:0] st_mode = lvc_pkg::MODE_ON;
  logic st_flag = 1'b0;
  logic [15:0] st_sum = '0;
  logic [6:0] st_cnt = '0;
  logic st_green = 1'b1;
  logic st_red = 1'b0;
  logic st_load = 1'b1;

  lvc_pkg::result_t pending_status[$];
  stim_row_t dir_rows[$];
  lvc_pkg::levels_t lvl_plan[NUM_SETS];

  low_voltage_cutoff_controller #(
    .OVERSAMPLE_LOG2(WIN_LOG2)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_load_enable(out_load_enable),
    .out_green_led(out_green_led),
    .out_red_led(out_red_led),
    .out_mode(out_mode),
    .out_window_done(out_window_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle);
  end

  function automatic void enter_mode(input logic [lvc_pkg::MODE_W-1:0] m);
    st_mode = m;
    st_green = (m == lvc_pkg::MODE_ON);
    st_red = (m == lvc_pkg::MODE_OFF);
    st_load = (m == lvc_pkg::MODE_ON);
  endfunction

  function automatic lvc_pkg::result_t predict_status(input logic op,
                                                      input lvc_pkg::level_t smp);
    logic [15:0] avg;
    logic done;
    logic awake;
    awake = (st_mode == lvc_pkg::MODE_ON) || (st_mode == lvc_pkg::MODE_OFF);
    done = 1'b0;
    if (op) begin
      st_sum = '0;
      st_cnt = '0;
      if (awake) enter_mode(lvc_pkg::MODE_SLEEP);
      else if (st_flag) enter_mode(lvc_pkg::MODE_OFF);
      else enter_mode(lvc_pkg::MODE_ON);
    end else if (awake) begin
      st_sum = st_sum + 16'(smp);
      st_cnt = st_cnt + 7'd1;
      if (int'(st_cnt) >= WINDOW) begin
        avg = st_sum >> WIN_LOG2;
        st_sum = '0;
        st_cnt = '0;
        done = 1'b1;
        if (st_mode == lvc_pkg::MODE_ON) begin
          if (avg < 16'(lvl.cutoff)) begin
            st_flag = 1'b1;
            enter_mode(lvc_pkg::MODE_OFF);
          end else if (avg < 16'(lvl.low)) begin
            st_red = 1'b1;
          end
        end else if (avg > 16'(lvl.recover)) begin
          st_flag = 1'b0;
          enter_mode(lvc_pkg::MODE_ON);
        end
      end
    end
    return lvc_pkg::result_t'{st_load, st_green, st_red, st_mode, done};
  endfunction

  function automatic lvc_pkg::level_t to_level(input int v);
    if (v < 0) return '0;
    if (v > 1023) return 10'd1023;
    return lvc_pkg::level_t'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH cycle %0d result %0d: %s", cycle, results, what);
  endtask

  always @(posedge clk) begin
    lvc_pkg::result_t got;
    lvc_pkg::result_t want;
    lvc_pkg::result_t pred;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accepted++;
        pred = predict_status(in_operation, in_sample);
        pending_status.push_back(row_typed ? row_exp : pred);
      end
      if (out_valid && out_ready) begin
        results++;
        got = lvc_pkg::result_t'{out_load_enable, out_green_led, out_red_led, out_mode,
                                 out_window_done};
        if (got.window_done) windows++;
        if (got.window_done && got.mode == lvc_pkg::MODE_OFF) cutoffs++;
        if (pending_status.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = pending_status.pop_front();
          if (got.load_enable !== want.load_enable)
            report_mismatch($sformatf("load_enable %0b, want %0b", got.load_enable,
                                      want.load_enable));
          if (got.green_led !== want.green_led)
            report_mismatch($sformatf("green_led %0b, want %0b", got.green_led, want.green_led));
          if (got.red_led !== want.red_led)
            report_mismatch($sformatf("red_led %0b, want %0b", got.red_led, want.red_led));
          if (got.mode !== want.mode)
            report_mismatch($sformatf("mode %0d, want %0d", got.mode, want.mode));
          if (got.window_done !== want.window_done)
            report_mismatch($sformatf("window_done %0b, want %0b", got.window_done,
                                      want.window_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d with %0d results pending", cycle, pending_status.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic op, input lvc_pkg::level_t smp, input logic typed,
                           input lvc_pkg::result_t exp);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_sample = smp;
    row_typed = typed;
    row_exp = exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_level(input logic [lvc_pkg::CFG_IDX_W-1:0] idx,
                             input lvc_pkg::level_t val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lvc_pkg::REG_CUTOFF: lvl.cutoff = val;
      lvc_pkg::REG_LOW: lvl.low = val;
      lvc_pkg::REG_RECOVER: lvl.recover = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic press_button();
    send_item(1'b1, lvc_pkg::level_t'($urandom), 1'b0, '0);
  endtask

  // mostly whole windows aimed at the thresholds, mixed with presses and stray samples
  task automatic drive_random_traffic(input int n_items);
    int sent;
    int base;
    logic exact;
    sent = 0;
    while (sent < n_items) begin
      if (st_mode == lvc_pkg::MODE_SLEEP && $urandom_range(3) != 0) begin
        press_button();
        sent++;
      end else if ($urandom_range(99) < 6) begin
        press_button();
        sent++;
      end else if ($urandom_range(99) < 15) begin
        if (st_mode != lvc_pkg::MODE_SLEEP) sent++;
        send_item(1'b0, lvc_pkg::level_t'($urandom), 1'b0, '0);
      end else begin
        case ($urandom_range(3))
          0: base = int'(lvl.cutoff);
          1: base = int'(lvl.low);
          2: base = int'(lvl.recover);
          default: base = int'($urandom_range(1023));
        endcase
        base = base + int'($urandom_range(4)) - 2;
        exact = $urandom_range(1);
        for (int k = 0; k < WINDOW; k++) begin
          if ($urandom_range(99) < 3) begin
            press_button();
            sent++;
          end else begin
            if (st_mode != lvc_pkg::MODE_SLEEP) sent++;
            send_item(1'b0, to_level(exact ? base : base + int'($urandom_range(6)) - 3),
                      1'b0, '0);
          end
        end
      end
    end
  endtask

  initial begin
    lvl_plan[0] = '{lvc_pkg::CUTOFF_RST, lvc_pkg::LOW_RST, lvc_pkg::RECOVER_RST};
    lvl_plan[1] = '{10'd0, 10'd0, 10'd0};
    lvl_plan[2] = '{10'd1023, 10'd1023, 10'd1023};
    lvl_plan[3] = '{10'd900, 10'd500, 10'd300};
    lvl_plan[4] = '{lvc_pkg::level_t'($urandom_range(1023)),
                    lvc_pkg::level_t'($urandom_range(1023)),
                    lvc_pkg::level_t'($urandom_range(1023))};
    lvl_plan[5] = '{lvc_pkg::level_t'($urandom_range(1023)),
                    lvc_pkg::level_t'($urandom_range(1023)),
                    lvc_pkg::level_t'($urandom_range(1023))};

    // sleep and wake, ignored samples in sleep, window cleared by the button,
    // cutoff at the low extreme and recovery at the high extreme
    dir_rows.push_back('{1'b1, 10'd0, 1'b1, ST_SLEEP});
    dir_rows.push_back('{1'b0, 10'd1023, 1'b1, ST_SLEEP});
    dir_rows.push_back('{1'b1, 10'd1023, 1'b1, ST_ON});
    for (int i = 0; i < 3; i++) dir_rows.push_back('{1'b0, 10'd1023, 1'b0, ST_ON});
    dir_rows.push_back('{1'b1, 10'd0, 1'b1, ST_SLEEP});
    dir_rows.push_back('{1'b1, 10'd0, 1'b1, ST_ON});
    for (int i = 0; i < WINDOW - 1; i++) dir_rows.push_back('{1'b0, 10'd0, 1'b1, ST_ON});
    dir_rows.push_back('{1'b0, 10'd0, 1'b1, ST_CUTOFF});
    dir_rows.push_back('{1'b1, 10'd0, 1'b1, ST_SLEEP});
    dir_rows.push_back('{1'b1, 10'd0, 1'b1, ST_OFF});
    for (int i = 0; i < WINDOW - 1; i++) dir_rows.push_back('{1'b0, 10'd1023, 1'b1, ST_OFF});
    dir_rows.push_back('{1'b0, 10'd1023, 1'b1, ST_RECOVER});

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].typed,
                                    dir_rows[i].exp);
    in_valid = 1'b0;
    row_typed = 1'b0;

    for (int s = 0; s < NUM_SETS; s++) begin
      in_valid = 1'b0;
      while (pending_status.size() != 0) @(negedge clk);
      send_idle = (s < 2) ? 35 : (s < 4) ? 66 : 0;
      recv_idle = (s < 2) ? 66 : (s < 4) ? 35 : 0;
      write_level(lvc_pkg::REG_CUTOFF, lvl_plan[s].cutoff);
      write_level(lvc_pkg::REG_LOW, lvl_plan[s].low);
      write_level(lvc_pkg::REG_RECOVER, lvl_plan[s].recover);
      cfg_valid = 1'b0;
      drive_random_traffic(RANDOM_PER_SET);
    end
    in_valid = 1'b0;

    while (pending_status.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Checked %0d results from %0d transactions (%0d directed) over %0d level settings",
             results, accepted, dir_rows.size(), NUM_SETS);
    $display("Closed %0d averaging windows, %0d of them ending in the off mode", windows,
             cutoffs);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lvc_pkg.sv
rtl/lvc_cfg_regs.sv
rtl/lvc_core.sv
rtl/low_voltage_cutoff_controller.sv
dv/tb_low_voltage_cutoff_controller.sv
